// ===== src/crc8fr_pkg.sv =====
// Shared types, codes and the CRC-8 byte update for the checked frame receiver.
package crc8fr_pkg;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

  localparam logic ADDR_HEADER_FIRST  = 1'b0;
  localparam logic ADDR_HEADER_SECOND = 1'b1;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hAA;

  typedef enum logic [7:0] {
    PH_HUNT1   = 8'b0000_0001,
    PH_HUNT2   = 8'b0000_0010,
    PH_LEN     = 8'b0000_0100,
    PH_PAYLOAD = 8'b0000_1000,
    PH_CRC     = 8'b0001_0000,
    PH_RD_ADDR = 8'b0010_0000,
    PH_RD_DATA = 8'b0100_0000,
    PH_DONE    = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } hdr_cfg_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/crc8fr_regs.sv =====
// APB-style register file holding the two expected header bytes.
module crc8fr_regs
  import crc8fr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output hdr_cfg_t    hdr_cfg
);

  hdr_cfg_t hdr_r, hdr_nxt;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    hdr_nxt = hdr_r;
    if (wr_en) begin
      unique case (paddr[2])
        ADDR_HEADER_FIRST:  hdr_nxt.first  = pwdata[7:0];
        ADDR_HEADER_SECOND: hdr_nxt.second = pwdata[7:0];
        default:            hdr_nxt        = hdr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r.first  <= HEADER_FIRST_RST;
      hdr_r.second <= HEADER_SECOND_RST;
    end else begin
      hdr_r <= hdr_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      ADDR_HEADER_FIRST:  prdata = {24'd0, hdr_r.first};
      ADDR_HEADER_SECOND: prdata = {24'd0, hdr_r.second};
      default:            prdata = 32'd0;
    endcase
  end

  assign hdr_cfg = hdr_r;

endmodule

// ===== src/crc8fr_store.sv =====
// Payload byte store with one write port and one registered read port.
module crc8fr_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/crc8fr_parser.sv =====
// Frame parser: header hunt, CRC tracking, payload capture and result sequencing.
module crc8fr_parser
  import crc8fr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hdr_cfg_t      hdr_cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_rx_byte,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_kind,
  output logic [3:0]    out_byte_index,
  output logic [7:0]    out_payload_byte,
  output logic [1:0]    out_status,
  output logic          out_last,
  output logic          st_we,
  output logic [AW-1:0] st_waddr,
  output logic [7:0]    st_wdata,
  output logic          st_re,
  output logic [AW-1:0] st_raddr,
  input  logic [7:0]    st_rdata
);

  localparam logic [7:0]    MAX_LEN  = 8'(MAX_PAYLOAD);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_PAYLOAD);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  phase_t        phase_r, phase_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [CW-1:0] seen_r, seen_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          kind_r, kind_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          last_r, last_nxt;

  logic          slot_free;
  logic          taking;
  logic          accept;
  logic          load;
  logic [CW-1:0] seen_inc;
  logic [CW+3:0] rd_wide;

  assign slot_free = !out_valid_r || !out_stall;
  assign taking    = (phase_r == PH_HUNT1) || (phase_r == PH_HUNT2) ||
                     (phase_r == PH_LEN) || (phase_r == PH_PAYLOAD) || (phase_r == PH_CRC);
  assign in_stall  = !taking || !slot_free;
  assign accept    = in_valid && !in_stall;
  assign seen_inc  = seen_r + CNT_ONE;
  assign rd_wide   = {4'd0, rd_r};

  assign st_we    = accept && (phase_r == PH_PAYLOAD);
  assign st_waddr = seen_r[AW-1:0];
  assign st_wdata = in_rx_byte;
  assign st_re    = (phase_r == PH_RD_ADDR);
  assign st_raddr = rd_r[AW-1:0];

  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    rd_nxt     = rd_r;
    load       = 1'b0;
    kind_nxt   = KIND_STATUS;
    idx_nxt    = 4'd0;
    byte_nxt   = 8'd0;
    status_nxt = STATUS_OK;
    last_nxt   = 1'b1;

    unique case (phase_r)
      PH_HUNT1, PH_HUNT2: begin
        if (accept) begin
          if (phase_r == PH_HUNT2 && in_rx_byte == hdr_cfg.second) begin
            crc_nxt   = crc8_feed(crc_r, in_rx_byte);
            phase_nxt = PH_LEN;
          end else if (in_rx_byte == hdr_cfg.first) begin
            crc_nxt   = crc8_feed(8'd0, in_rx_byte);
            phase_nxt = PH_HUNT2;
          end else begin
            crc_nxt   = 8'd0;
            phase_nxt = PH_HUNT1;
          end
        end
      end
      PH_LEN: begin
        if (accept) begin
          len_nxt  = in_rx_byte;
          crc_nxt  = crc8_feed(crc_r, in_rx_byte);
          seen_nxt = '0;
          if (in_rx_byte > MAX_LEN) begin
            load       = 1'b1;
            status_nxt = STATUS_LEN_ERR;
            phase_nxt  = PH_HUNT1;
          end else if (in_rx_byte == 8'd0) begin
            phase_nxt = PH_CRC;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (accept) begin
          crc_nxt  = crc8_feed(crc_r, in_rx_byte);
          seen_nxt = seen_inc;
          if (8'(seen_inc) >= len_r || seen_inc == MAX_CNT) begin
            phase_nxt = PH_CRC;
          end
        end
      end
      PH_CRC: begin
        if (accept) begin
          crc_nxt   = 8'd0;
          phase_nxt = PH_HUNT1;
          rd_nxt    = '0;
          if (in_rx_byte != crc_r) begin
            load       = 1'b1;
            status_nxt = STATUS_CRC_ERR;
          end else if (len_r == 8'd0) begin
            load = 1'b1;
          end else begin
            phase_nxt = PH_RD_ADDR;
          end
        end
      end
      PH_RD_ADDR: begin
        phase_nxt = PH_RD_DATA;
      end
      PH_RD_DATA: begin
        if (slot_free) begin
          load      = 1'b1;
          kind_nxt  = KIND_BYTE;
          idx_nxt   = rd_wide[3:0];
          byte_nxt  = st_rdata;
          last_nxt  = 1'b0;
          rd_nxt    = rd_r + CNT_ONE;
          phase_nxt = (rd_r + CNT_ONE == seen_r) ? PH_DONE : PH_RD_ADDR;
        end
      end
      PH_DONE: begin
        if (slot_free) begin
          load      = 1'b1;
          phase_nxt = PH_HUNT1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT1;
      crc_r       <= 8'd0;
      len_r       <= 8'd0;
      seen_r      <= '0;
      rd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      crc_r       <= crc_nxt;
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= kind_nxt;
      idx_r    <= idx_nxt;
      byte_r   <= byte_nxt;
      status_r <= status_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_byte_index   = idx_r;
  assign out_payload_byte = byte_r;
  assign out_status       = status_r;
  assign out_last         = last_r;

endmodule

// ===== src/crc8_checked_frame_receiver_core.sv =====
// Top level of the CRC-8 checked serial frame receiver.
//
// The input channel (in_valid, in_stall, in_rx_byte) takes one received byte
// per transaction. The receiver hunts for the two header bytes, reads a length
// byte and the payload into a store, and checks the following CRC-8 byte.
// Each result leaves on the output channel as one transaction with kind,
// byte_index, payload_byte, status and last; last marks the final result of
// the byte that caused it. An input byte is accepted whenever no
// readout is running and the output register is free or being drained.
// A byte that causes a single status result shows it in the next cycle.
// A good CRC byte after a nonempty payload starts a readout from the payload
// store: each payload result passes a store read state and then a state that
// loads the output register, and the ok status follows the last payload byte.
// Input is stalled for the length of that readout.
// Reset restores the header bytes to 0x55 and 0xAA and returns to the hunt;
// the payload store is not cleared. While out_stall is high and a result is
// pending, the output transaction holds and the receiver stalls its own input.
module crc8_checked_frame_receiver_core
  import crc8fr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [3:0]  out_byte_index,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  hdr_cfg_t      hdr_cfg;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [7:0]    st_wdata;
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic [7:0]    st_rdata;

  crc8fr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hdr_cfg (hdr_cfg)
  );

  crc8fr_store #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  crc8fr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .CW          (CW)
  ) u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .hdr_cfg          (hdr_cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_last         (out_last),
    .st_we            (st_we),
    .st_waddr         (st_waddr),
    .st_wdata         (st_wdata),
    .st_re            (st_re),
    .st_raddr         (st_raddr),
    .st_rdata         (st_rdata)
  );

endmodule

// ===== tb/sv/crc8_checked_frame_receiver_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts the frame receiver's results and compares each output transaction.
module crc8_checked_frame_receiver_checker
  import crc8fr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [3:0]  out_byte_index,
  input  logic [7:0]  out_payload_byte,
  input  logic [1:0]  out_status,
  input  logic        out_last,
  output int          mismatch_count,
  output int          pending_results
);

  typedef enum logic [4:0] {
    SEEK_FIRST   = 5'b0_0001,
    SEEK_SECOND  = 5'b0_0010,
    READ_LENGTH  = 5'b0_0100,
    READ_PAYLOAD = 5'b0_1000,
    READ_CRC     = 5'b1_0000
  } rx_phase_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] byte_index;
    logic [7:0] payload;
    logic [1:0] status;
    logic       last;
  } frame_result_t;

  frame_result_t expected_results[$];
  rx_phase_t     rx_phase;
  logic [7:0]    hdr_first_q;
  logic [7:0]    hdr_second_q;
  logic [7:0]    crc_acc;
  logic [7:0]    frame_len;
  int            bytes_taken;
  logic [7:0]    payload_copy [MAX_PAYLOAD];

  function automatic logic [7:0] crc8_maxim_update(input logic [7:0] acc,
                                                   input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void queue_result(input logic kind, input logic [3:0] idx,
                                       input logic [7:0] value, input logic [1:0] status,
                                       input logic last);
    expected_results.push_back('{kind, idx, value, status, last});
  endfunction

  function automatic void seek_header(input logic [7:0] b);
    if (b == hdr_first_q) begin
      crc_acc = crc8_maxim_update(8'h00, b);
      rx_phase = SEEK_SECOND;
    end else begin
      crc_acc = 8'h00;
      rx_phase = SEEK_FIRST;
    end
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b);
    case (rx_phase)
      SEEK_FIRST: begin
        seek_header(b);
      end
      SEEK_SECOND: begin
        if (b == hdr_second_q) begin
          crc_acc = crc8_maxim_update(crc_acc, b);
          rx_phase = READ_LENGTH;
        end else begin
          seek_header(b);
        end
      end
      READ_LENGTH: begin
        frame_len = b;
        crc_acc = crc8_maxim_update(crc_acc, b);
        bytes_taken = 0;
        if (b > MAX_PAYLOAD) begin
          queue_result(KIND_STATUS, 4'd0, 8'd0, STATUS_LEN_ERR, 1'b1);
          rx_phase = SEEK_FIRST;
        end else if (b == 8'd0) begin
          rx_phase = READ_CRC;
        end else begin
          rx_phase = READ_PAYLOAD;
        end
      end
      READ_PAYLOAD: begin
        if (bytes_taken < MAX_PAYLOAD) payload_copy[bytes_taken] = b;
        crc_acc = crc8_maxim_update(crc_acc, b);
        bytes_taken++;
        if (bytes_taken >= frame_len || bytes_taken >= MAX_PAYLOAD) rx_phase = READ_CRC;
      end
      default: begin
        if (b == crc_acc) begin
          for (int i = 0; i < frame_len && i < MAX_PAYLOAD; i++) begin
            queue_result(KIND_BYTE, 4'(i), payload_copy[i], STATUS_OK, 1'b0);
          end
          queue_result(KIND_STATUS, 4'd0, 8'd0, STATUS_OK, 1'b1);
        end else begin
          queue_result(KIND_STATUS, 4'd0, 8'd0, STATUS_CRC_ERR, 1'b1);
        end
        rx_phase = SEEK_FIRST;
        crc_acc = 8'h00;
      end
    endcase
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result transaction, expected none, actual kind %0d status %0d",
               $time, out_kind, out_status);
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 8'(want.kind), 8'(out_kind));
      check_field("byte_index", 8'(want.byte_index), 8'(out_byte_index));
      check_field("payload_byte", want.payload, out_payload_byte);
      check_field("status", 8'(want.status), 8'(out_status));
      check_field("last", 8'(want.last), 8'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase = SEEK_FIRST;
      crc_acc = 8'h00;
      frame_len = 8'h00;
      bytes_taken = 0;
      hdr_first_q = HEADER_FIRST_RST;
      hdr_second_q = HEADER_SECOND_RST;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          ADDR_HEADER_FIRST:  hdr_first_q = pwdata[7:0];
          ADDR_HEADER_SECOND: hdr_second_q = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_rx_byte(in_rx_byte);
    end
    pending_results = expected_results.size();
  end

endmodule

// ===== tb/sv/crc8_checked_frame_receiver_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top that drives bytes, header writes and output stalls and gives the verdict.
module crc8_checked_frame_receiver_core_tb
  import crc8fr_pkg::*;
();

  localparam int MAX_PAYLOAD     = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 20;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [3:0]  out_byte_index;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_status;
  logic        out_last;

  int          mismatch_count;
  int          pending_results;
  int          cycle_count = 0;
  logic        steady_flow = 1'b0;
  logic        sink_hold_req = 1'b0;
  logic        sink_hold_done = 1'b0;
  logic [7:0]  hdr_first = HEADER_FIRST_RST;
  logic [7:0]  hdr_second = HEADER_SECOND_RST;

  crc8_checked_frame_receiver_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) uut (.*);

  crc8_checked_frame_receiver_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) frame_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The sink stalls the output at random unless steady_flow is set, plus one long hold-off that backs up the block.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req && !sink_hold_done) begin
        sink_hold_done = 1'b1;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= !steady_flow && ($urandom_range(99) < 34);
    end
  end

  function automatic logic [7:0] frame_crc_step(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 12) return 8'(MAX_PAYLOAD);
    if (r < 25) return 8'd0;
    if (r < 70) return 8'($urandom_range(4, 1));
    return 8'($urandom_range(MAX_PAYLOAD - 1, 5));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!steady_flow && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] len, input logic bad_crc);
    logic [7:0] crc;
    logic [7:0] b;
    crc = frame_crc_step(frame_crc_step(frame_crc_step(8'h00, hdr_first), hdr_second), len);
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(len);
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        crc = frame_crc_step(crc, b);
        send_byte(b);
      end
      send_byte(bad_crc ? (crc ^ 8'($urandom_range(255, 1))) : crc);
    end
  endtask

  task automatic run_traffic(input int count);
    int sent;
    int pick;
    logic [7:0] len;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = pick_length();
        send_frame(len, 1'b0);
        sent += 4 + int'(len);
      end else if (pick < 77) begin
        len = pick_length();
        send_frame(len, 1'b1);
        sent += 4 + int'(len);
      end else if (pick < 85) begin
        send_frame(8'($urandom_range(255, MAX_PAYLOAD + 1)), 1'b0);
        sent += 3;
      end else if (pick < 92) begin
        send_byte(hdr_first);
        send_byte(8'($urandom));
        sent += 2;
      end else begin
        send_byte(8'($urandom));
        sent += 1;
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_header(input logic idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_headers(input logic [7:0] first_b, input logic [7:0] second_b);
    drain_results();
    write_header(ADDR_HEADER_FIRST, first_b);
    write_header(ADDR_HEADER_SECOND, second_b);
    hdr_first = first_b;
    hdr_second = second_b;
  endtask

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_rx_byte <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(8'd0, 1'b0);
    send_frame(8'd1, 1'b0);
    send_frame(8'(MAX_PAYLOAD + 1), 1'b0);
    send_frame(8'hFF, 1'b0);
    send_frame(8'd0, 1'b1);
    send_byte(hdr_first);
    send_byte(8'h00);
    // A repeated first header byte restarts the hunt with a fresh CRC.
    send_byte(hdr_first);
    send_frame(8'd0, 1'b0);

    set_headers(8'h00, 8'hFF);
    run_traffic(80);
    set_headers(8'hFF, 8'h00);
    steady_flow = 1'b1;
    run_traffic(60);
    steady_flow = 1'b0;
    set_headers(8'h3C, 8'h3C);
    run_traffic(60);
    set_headers(8'($urandom), 8'($urandom));
    sink_hold_req = 1'b1;
    run_traffic(80);
    set_headers(HEADER_FIRST_RST, HEADER_SECOND_RST);
    run_traffic(70);
    drain_results();

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
